// File: sv/eafr_pkg.sv
// ----------------------------------------------------------------------------
// eafr_pkg: shared types and constants for the escaped API frame receiver
// Frame syntax codes, parser phases, event codes and store geometry.
// ----------------------------------------------------------------------------
package eafr_pkg;

   // Payload capacity per bank; the store holds two banks.
   localparam int PAYLOAD_MAX = 128;
   localparam int STORE_DEPTH = 2 * PAYLOAD_MAX;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Frame syntax
   localparam logic [7:0]  DELIM_BYTE   = 8'h7E;
   localparam logic [7:0]  ESC_BYTE     = 8'h7D;
   localparam logic [7:0]  ESC_XOR      = 8'h20;
   localparam logic [7:0]  SUM_GOOD     = 8'hFF;
   localparam logic [15:0] KIND_POS     = 16'd13;
   localparam logic [15:0] PAYLOAD_POS  = 16'd14;
   localparam logic [7:0]  FRAME_TYPE_RESET = 8'd144;

   typedef enum logic [1:0] {
      FN_BYTE = 2'd0,
      FN_READ = 2'd1,
      FN_ACK  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_ACCEPT  = 3'd1,
      EV_BADSUM  = 3'd2,
      EV_MISSED  = 3'd3,
      EV_IGNORED = 3'd4,
      EV_RESYNC  = 3'd5
   } event_type;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_LEN_MSB = 3'd1,
      PH_LEN_LSB = 3'd2,
      PH_TYPE    = 3'd3,
      PH_BODY    = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   // One result word
   typedef struct packed {
      event_type   event_res;
      logic        message_pending;
      logic [7:0]  message_kind;
      logic [15:0] message_length;
      logic [7:0]  read_data;
      logic [15:0] missed_total;
   } rsp_word_type;

   // First store address of a bank
   function automatic logic [ADDR_W-1:0] bank_base(input logic bank);
      return bank ? ADDR_W'(PAYLOAD_MAX) : '0;
   endfunction

endpackage

// File: sv/eafr_if.sv
// ----------------------------------------------------------------------------
// eafr_if: channel interfaces of the escaped API frame receiver
// Request, response and control-register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface eafr_req_if import eafr_pkg::*;;
   logic       valid;
   logic       ready;
   func_type   func;
   logic [7:0] rx_byte;
   logic [6:0] read_index;

   modport source (output valid, func, rx_byte, read_index, input ready);
   modport sink   (input valid, func, rx_byte, read_index, output ready);
endinterface

interface eafr_rsp_if import eafr_pkg::*;;
   logic        valid;
   logic        ready;
   event_type   event_res;
   logic        message_pending;
   logic [7:0]  message_kind;
   logic [15:0] message_length;
   logic [7:0]  read_data;
   logic [15:0] missed_total;

   modport source (output valid, event_res, message_pending, message_kind,
                    message_length, read_data, missed_total, input ready);
   modport sink   (input valid, event_res, message_pending, message_kind,
                    message_length, read_data, missed_total, output ready);
endinterface

interface eafr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] accepted_frame_type;

   modport source (output valid, accepted_frame_type, input ready);
   modport sink   (input valid, accepted_frame_type, output ready);
endinterface

// File: sv/eafr_ram.sv
// ----------------------------------------------------------------------------
// eafr_ram: generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module eafr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds when no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/escaped_api_frame_receiver.sv
// ----------------------------------------------------------------------------
// escaped_api_frame_receiver: escaped API frame parser with message store
// Parses serial bytes into frames, checks the sum, publishes payload into a
// double-buffered RAM and serves payload reads and acknowledges.
// ----------------------------------------------------------------------------
// Path: a result word passes the stage 1 register, which waits on the
//   registered payload RAM read, and then the output register; rsp.ready
//   low holds it in stage 1 or the output register.
// Throughput: one request word per cycle, sustained while rsp.ready is high.
// Reset: synchronous; parser, flags, counters and the frame type register
//   (to 144) clear at once. The payload RAM is not cleared, no clearing pass.
module escaped_api_frame_receiver import eafr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   eafr_req_if.sink   req,
   eafr_rsp_if.source rsp,
   eafr_csr_if.sink   csr
);

   // Architectural state
   logic [7:0]  frame_type_ff;
   phase_type   phase_ff, phase_in;
   logic        esc_ff, esc_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  kind_ff, kind_in;
   logic        bank_ff, bank_in;
   logic        pend_ff, pend_in;
   logic [7:0]  pub_kind_ff, pub_kind_in;
   logic [15:0] pub_len_ff, pub_len_in;
   logic [15:0] missed_ff, missed_in;
   event_type   ev_in;

   // Payload RAM ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              rd_hit;

   // Pipeline: stage 1 waits on the RAM read, then the output register
   logic         s1_valid_ff, s1_valid_in;
   rsp_word_type s1_word_ff;
   logic         s1_hit_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   logic         s1_move;
   logic         req_accept;

   // Handshake
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_move;
   assign req_accept = req.valid && req.ready;
   assign csr.ready  = 1'b1;

   // Frame type register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_type_ff <= FRAME_TYPE_RESET;
      end else if (csr.valid) begin
         frame_type_ff <= csr.accepted_frame_type;
      end
   end

   // Parser state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         esc_ff      <= 1'b0;
         len_ff      <= '0;
         count_ff    <= '0;
         sum_ff      <= '0;
         kind_ff     <= '0;
         bank_ff     <= 1'b0;
         pend_ff     <= 1'b0;
         pub_kind_ff <= '0;
         pub_len_ff  <= '0;
         missed_ff   <= '0;
      end else begin
         phase_ff    <= phase_in;
         esc_ff      <= esc_in;
         len_ff      <= len_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         kind_ff     <= kind_in;
         bank_ff     <= bank_in;
         pend_ff     <= pend_in;
         pub_kind_ff <= pub_kind_in;
         pub_len_ff  <= pub_len_in;
         missed_ff   <= missed_in;
      end
   end

   // Next state, store accesses and event for the word being taken
   always_comb begin
      logic [7:0]  b;
      logic [7:0]  total;
      logic [15:0] pos;
      logic [15:0] stored;

      phase_in    = phase_ff;
      esc_in      = esc_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      kind_in     = kind_ff;
      bank_in     = bank_ff;
      pend_in     = pend_ff;
      pub_kind_in = pub_kind_ff;
      pub_len_in  = pub_len_ff;
      missed_in   = missed_ff;
      ev_in       = EV_NONE;
      b           = req.rx_byte;
      total       = sum_ff + b;
      pos         = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = req.rx_byte;
      rd_en       = 1'b0;
      rd_addr     = '0;
      rd_hit      = 1'b0;
      stored      = (pub_len_ff > 16'(PAYLOAD_MAX)) ? 16'(PAYLOAD_MAX) : pub_len_ff;

      if (req_accept) begin
         unique case (req.func)
            FN_BYTE: begin
               priority if (req.rx_byte == DELIM_BYTE) begin
                  // delimiter always opens a frame; mid-frame it is a resync
                  ev_in    = (phase_ff != PH_START) ? EV_RESYNC : EV_NONE;
                  phase_in = PH_LEN_MSB;
                  esc_in   = 1'b0;
                  len_in   = '0;
                  count_in = '0;
                  sum_in   = '0;
                  kind_in  = '0;
               end else if (phase_ff == PH_START) begin
                  // idle: ignore everything but the delimiter
                  phase_in = PH_START;
               end else if (req.rx_byte == ESC_BYTE && !esc_ff) begin
                  esc_in = 1'b1;
               end else begin
                  if (esc_ff) begin
                     b      = req.rx_byte ^ ESC_XOR;
                     esc_in = 1'b0;
                  end
                  total   = sum_ff + b;
                  wr_data = b;
                  unique case (phase_ff)
                     PH_LEN_MSB: begin
                        len_in   = {b, 8'd0};
                        phase_in = PH_LEN_LSB;
                     end
                     PH_LEN_LSB: begin
                        len_in   = {len_ff[15:8], b};
                        phase_in = PH_TYPE;
                     end
                     PH_TYPE: begin
                        sum_in   = total;
                        count_in = 16'd1;
                        if (b != frame_type_ff) begin
                           phase_in = PH_START;
                           ev_in    = EV_IGNORED;
                        end else begin
                           phase_in = (len_ff <= 16'd1) ? PH_CHECK : PH_BODY;
                        end
                     end
                     PH_BODY: begin
                        sum_in   = total;
                        count_in = count_ff + 16'd1;
                        if (count_in == KIND_POS) begin
                           kind_in = b;
                        end else if (count_in >= PAYLOAD_POS) begin
                           // payload goes to the unpublished bank
                           pos = count_in - PAYLOAD_POS;
                           if (pos < 16'(PAYLOAD_MAX)) begin
                              wr_en   = 1'b1;
                              wr_addr = bank_base(!bank_ff) + ADDR_W'(pos);
                           end
                        end
                        if (count_in >= len_ff) begin
                           phase_in = PH_CHECK;
                        end
                     end
                     PH_CHECK: begin
                        phase_in = PH_START;
                        priority if (total != SUM_GOOD) begin
                           ev_in = EV_BADSUM;
                        end else if (pend_ff) begin
                           missed_in = (missed_ff != 16'hFFFF) ? missed_ff + 16'd1
                                                               : missed_ff;
                           ev_in     = EV_MISSED;
                        end else begin
                           pend_in     = 1'b1;
                           bank_in     = !bank_ff;
                           pub_kind_in = kind_ff;
                           pub_len_in  = (len_ff >= KIND_POS) ? len_ff - KIND_POS : '0;
                           ev_in       = EV_ACCEPT;
                        end
                     end
                     default: begin
                        phase_in = PH_START;
                     end
                  endcase
               end
            end
            FN_READ: begin
               rd_hit  = {9'd0, req.read_index} < stored;
               rd_en   = rd_hit;
               rd_addr = bank_base(bank_ff) + ADDR_W'(req.read_index);
            end
            FN_ACK: begin
               pend_in = 1'b0;
            end
            default: begin
               pend_in = pend_ff;
            end
         endcase
      end
   end

   // Payload store, two banks
   eafr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Pipeline valid flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Stage 1 word: state after the step; read data joins at the output register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff.event_res       <= ev_in;
         s1_word_ff.message_pending <= pend_in;
         s1_word_ff.message_kind    <= pub_kind_in;
         s1_word_ff.message_length  <= pub_len_in;
         s1_word_ff.read_data       <= '0;
         s1_word_ff.missed_total    <= missed_in;
         s1_hit_ff                  <= rd_hit;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_word_ff.event_res       <= s1_word_ff.event_res;
         out_word_ff.message_pending <= s1_word_ff.message_pending;
         out_word_ff.message_kind    <= s1_word_ff.message_kind;
         out_word_ff.message_length  <= s1_word_ff.message_length;
         out_word_ff.read_data       <= s1_hit_ff ? rd_data : s1_word_ff.read_data;
         out_word_ff.missed_total    <= s1_word_ff.missed_total;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.event_res       = out_word_ff.event_res;
   assign rsp.message_pending = out_word_ff.message_pending;
   assign rsp.message_kind    = out_word_ff.message_kind;
   assign rsp.message_length  = out_word_ff.message_length;
   assign rsp.read_data       = out_word_ff.read_data;
   assign rsp.missed_total    = out_word_ff.missed_total;

   // A held stage 1 word is never overwritten by a new request
   a_s1_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |-> !req_accept)
      else $error("stage 1 overrun");

   // Store writes and reads never share a cycle
   a_ram_one_access: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("payload RAM write and read in one cycle");

   // Writes land only in the unpublished bank
   a_write_bank: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((wr_addr >= ADDR_W'(PAYLOAD_MAX)) != bank_ff))
      else $error("payload write into published bank");

   // An accepted frame leaves a pending message
   a_accept_pending: assert property (@(posedge clock) disable iff (reset)
      (req_accept && ev_in == EV_ACCEPT) |=> pend_ff)
      else $error("accepted frame not pending");

endmodule
